// ===== rtl/dddm_pkg.sv =====
package dddm_pkg;

   // Timestamp storage width default; the request field itself is always 32 bits.
   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int REQ_TIME_WIDTH     = 32;

   localparam int DIGIT_WIDTH   = 4;
   localparam int DEBOUNCE_WIDTH = 16;
   localparam int BRIGHT_WIDTH  = 8;
   localparam int PIXEL_WIDTH   = 24;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [DIGIT_WIDTH-1:0]    DIGIT_MAX        = 4'd9;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET   = 16'd400;
   localparam logic [BRIGHT_WIDTH-1:0]   BRIGHTNESS_RESET = 8'd51;

   // Action codes carried in req_tuser.
   localparam logic [1:0] ACT_UP     = 2'd0;
   localparam logic [1:0] ACT_DOWN   = 2'd1;
   localparam logic [1:0] ACT_RENDER = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BRIGHTNESS = 2'd1;

   // Glyph grid geometry.
   localparam logic [2:0] ROW_TOP = 3'd4;
   localparam logic [2:0] COL_MAX = 3'd4;

   // One queued render request.
   typedef struct packed {
      logic                   valid;
      logic [DIGIT_WIDTH-1:0] digit;
   } frame_req_type;

   // Bit (5 * row + col) of a glyph word is the pixel at that row and column.
   function automatic logic glyph_lit(input logic [DIGIT_WIDTH-1:0] d,
                                      input logic [2:0] row,
                                      input logic [2:0] col);
      logic [24:0] word;
      logic [4:0]  idx;
      case (d)
         4'd0:    word = {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
         4'd1:    word = {5'h0E, 5'h04, 5'h04, 5'h06, 5'h04};
         4'd2:    word = {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
         4'd3:    word = {5'h0E, 5'h08, 5'h0C, 5'h08, 5'h0E};
         4'd4:    word = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0A};
         4'd5:    word = {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
         4'd6:    word = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E};
         4'd7:    word = {5'h08, 5'h08, 5'h08, 5'h0A, 5'h0E};
         4'd8:    word = {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
         4'd9:    word = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0E};
         default: word = '0;
      endcase
      idx = 5'(row) * 5'd5 + 5'(col);
      return word[idx];
   endfunction

endpackage

// ===== rtl/dddm_front.sv =====
module dddm_front
   import dddm_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_action,
   input  logic [REQ_TIME_WIDTH-1:0]     req_time,
   input  logic [DEBOUNCE_WIDTH-1:0]     debounce_ms,
   input  logic                          queue_full,
   output frame_req_type                 push
);

   localparam int EXT_WIDTH = (TIME_WIDTH > REQ_TIME_WIDTH) ? TIME_WIDTH : REQ_TIME_WIDTH;

   logic [DIGIT_WIDTH-1:0] digit_ff, digit_in;
   logic [TIME_WIDTH-1:0]  last_up_ff, last_up_in;
   logic [TIME_WIDTH-1:0]  last_down_ff, last_down_in;

   logic [EXT_WIDTH-1:0]   time_ext;
   logic [TIME_WIDTH-1:0]  t_now;
   logic [TIME_WIDTH-1:0]  up_gap;
   logic [TIME_WIDTH-1:0]  down_gap;
   logic                   up_ok;
   logic                   down_ok;
   logic                   accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Timestamps live modulo 2^TIME_WIDTH.
   assign time_ext = EXT_WIDTH'(req_time);
   assign t_now    = time_ext[TIME_WIDTH-1:0];
   assign up_gap   = t_now - last_up_ff;
   assign down_gap = t_now - last_down_ff;
   assign up_ok    = up_gap > TIME_WIDTH'(debounce_ms);
   assign down_ok  = down_gap > TIME_WIDTH'(debounce_ms);

   always_comb begin
      digit_in     = digit_ff;
      last_up_in   = last_up_ff;
      last_down_in = last_down_ff;
      push.valid   = 1'b0;
      push.digit   = digit_ff;
      if (accept) begin
         case (req_action)
            ACT_UP: begin
               if (up_ok) begin
                  last_up_in = t_now;
                  if (digit_ff < DIGIT_MAX) begin
                     digit_in = digit_ff + 4'd1;
                  end
               end
            end
            ACT_DOWN: begin
               if (down_ok) begin
                  last_down_in = t_now;
                  if (digit_ff != '0) begin
                     digit_in = digit_ff - 4'd1;
                  end
               end
            end
            ACT_RENDER: begin
               push.valid = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff     <= '0;
         last_up_ff   <= '0;
         last_down_ff <= '0;
      end else begin
         digit_ff     <= digit_in;
         last_up_ff   <= last_up_in;
         last_down_ff <= last_down_in;
      end
   end

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_ff <= DIGIT_MAX)
      else $error("digit left its range");

   a_reject_keeps_time: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_UP && !up_ok) |=> $stable(last_up_ff))
      else $error("rejected up press moved its timestamp");

endmodule

// ===== rtl/dddm_queue.sv =====
module dddm_queue
   import dddm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frame_req_type push,
   input  logic          pop,
   output frame_req_type head,
   output logic          full
);

   logic [DIGIT_WIDTH-1:0] slot_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = count_ff == 2'd2;
   assign head.valid = count_ff != 2'd0;
   assign head.digit = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count overflow");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("render request pushed into a full queue");

endmodule

// ===== rtl/dddm_render.sv =====
module dddm_render
   import dddm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  frame_req_type            head,
   output logic                     pop,
   input  logic [BRIGHT_WIDTH-1:0]  brightness,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [PIXEL_WIDTH-1:0]   rsp_tdata,
   output logic                     rsp_tlast
);

   logic                   busy_ff, busy_in;
   logic [DIGIT_WIDTH-1:0] digit_ff, digit_in;
   logic [2:0]             row_ff, row_in;
   logic [2:0]             step_ff, step_in;
   logic                   valid_ff, valid_in;
   logic [PIXEL_WIDTH-1:0] data_ff, data_in;
   logic                   last_ff, last_in;

   logic                   load;
   logic                   at_last;
   logic [2:0]             col;
   logic                   lit;

   // Even rows run from column 4 down, odd rows from column 0 up.
   assign col     = row_ff[0] ? step_ff : COL_MAX - step_ff;
   assign lit     = glyph_lit(digit_ff, row_ff, col);
   assign at_last = row_ff == '0 && step_ff == COL_MAX;
   assign load    = busy_ff && (!valid_ff || rsp_tready);
   assign pop     = head.valid && (!busy_ff || (load && at_last));

   always_comb begin
      busy_in  = busy_ff;
      digit_in = digit_ff;
      row_in   = row_ff;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = lit ? {8'd0, brightness, 8'd0} : '0;
         last_in  = at_last;
         if (step_ff == COL_MAX) begin
            step_in = '0;
            row_in  = row_ff - 3'd1;
         end else begin
            step_in = step_ff + 3'd1;
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in  = 1'b1;
         digit_in = head.digit;
         row_in   = ROW_TOP;
         step_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      row_ff   <= row_in;
      step_ff  <= step_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_ff <= ROW_TOP && step_ff <= COL_MAX))
      else $error("pixel scan left the glyph grid");

   a_red_only: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff[23:16] == '0 && data_ff[7:0] == '0))
      else $error("pixel carries green or blue");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> (busy_ff && row_ff == ROW_TOP && step_ff == '0))
      else $error("frame did not start at the top row");

endmodule

// ===== rtl/debounced_digit_matrix_display.sv =====
// Channel  | Direction | Signals                          | Contents
// req      | in        | req_tvalid/tready/tdata/tuser    | press or render request
// rsp      | out       | rsp_tvalid/tready/tdata/tlast    | one pixel word per transfer
// csr      | in        | csr_valid/ready/index/wdata      | configuration register write
//
// A press transfer is finished in the cycle it is taken; it produces no result.
// A render transfer yields 25 pixel transfers, one per cycle while rsp_tready is high,
// so the renderer's pixel counter sets the pace, and queued frames run back to back.
// Up to two render requests wait in a queue; req_tready drops only while it is full.
// Reset is synchronous and needs no clearing pass; the digit and both press times start at zero.
module debounced_digit_matrix_display
   import dddm_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] time_ms
   input  logic [1:0]                 req_tuser,   // [1:0] action
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [PIXEL_WIDTH-1:0]     rsp_tdata,   // [23:0] pixel_grb
   output logic                       rsp_tlast,   // last_pixel
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [DEBOUNCE_WIDTH-1:0]  csr_wdata
);

   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic [BRIGHT_WIDTH-1:0]   bright_ff, bright_in;
   frame_req_type             push;
   frame_req_type             head;
   logic                      queue_full;
   logic                      pop;

   // Configuration writes are always taken; an index beyond the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      bright_in   = bright_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_in = csr_wdata;
            CSR_BRIGHTNESS: bright_in   = csr_wdata[BRIGHT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         bright_ff   <= BRIGHTNESS_RESET;
      end else begin
         debounce_ff <= debounce_in;
         bright_ff   <= bright_in;
      end
   end

   // The front end applies presses to the digit in arrival order and snapshots the digit
   // for each render request, so later presses never alter a frame already queued.
   dddm_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tuser),
      .req_time    (req_tdata),
      .debounce_ms (debounce_ff),
      .queue_full  (queue_full),
      .push        (push)
   );

   dddm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   // The renderer scans the glyph in serpentine order into a registered output stage.
   dddm_render u_render (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .brightness (bright_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
